FILE: src/assert_macros.svh
// assertion macros shared by the timer queue rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/imht_pkg.sv
// types, codes and helpers of the indexed min-heap timer queue
`timescale 1ns / 1ps
package imht_pkg;

   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_FIRE  = 3'd1;
   localparam logic [2:0] OP_TICK  = 3'd2;
   localparam logic [2:0] OP_POP   = 3'd3;
   localparam logic [2:0] OP_CLEAR = 3'd4;

   localparam logic [1:0] KIND_ACK       = 2'd0;
   localparam logic [1:0] KIND_EXPIRED   = 2'd1;
   localparam logic [1:0] KIND_FIRED     = 2'd2;
   localparam logic [1:0] KIND_TICK_DONE = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [30:0] NEXT_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [2:0]  op;
      logic [9:0]  id;
      logic [30:0] timeout_ms;
      logic [47:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [9:0]  timer_id;
      logic [1:0]  status;
      logic        has_next;
      logic [30:0] next_ms;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] expiry;
      logic [9:0]  id;
   } heap_entry_type;

   typedef struct packed {
      logic        sub;
      logic [47:0] a;
      logic [47:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [47:0] value;
      logic        lt;
   } alu_rsp_type;

   function automatic rsp_type make_rsp(input logic [1:0] kind, input logic [9:0] tid,
                                        input logic [1:0] status, input logic has_next,
                                        input logic [30:0] next_ms, input logic last);
      rsp_type r;
      r.kind     = kind;
      r.timer_id = tid;
      r.status   = status;
      r.has_next = has_next;
      r.next_ms  = next_ms;
      r.last     = last;
      return r;
   endfunction

endpackage

FILE: src/imht_ram.sv
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps
module imht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/imht_alu.sv
// shared 48-bit adder: saturating add or compare-subtract
`timescale 1ns / 1ps
module imht_alu (
   input  imht_pkg::alu_req_type alu_req,
   output imht_pkg::alu_rsp_type alu_rsp
);

   logic [47:0] b_eff;
   logic [48:0] sum;

   // subtract as a + ~b + 1, carry out means no borrow
   assign b_eff = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign sum   = {1'b0, alu_req.a} + {1'b0, b_eff} + 49'(alu_req.sub);

   always_comb begin
      if (alu_req.sub) begin
         alu_rsp.value = sum[47:0];
         alu_rsp.lt    = ~sum[48];
      end else begin
         alu_rsp.value = sum[48] ? imht_pkg::TIME_MAX : sum[47:0];
         alu_rsp.lt    = 1'b0;
      end
   end

endmodule

FILE: src/indexed_min_heap_timer.sv
// top level of the indexed min-heap timer queue
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Timer queue kept as a binary min-heap on 48-bit expiry time, with a map from
// timer id to heap slot. A request is taken when start is high and busy is low;
// busy stays high until the final result of the request is on the result ports.
// Results come out one per strobe on rsp_valid and cannot be held off by the
// receiver; the final one of a request carries last. The heap and the id map
// are single-write, single-read rams with registered read, and one shared
// 48-bit adder does every expiry sum, difference and compare, so the block
// walks the heap one level at a time. A sift moves up or down one level per
// pass, log2(HEAP_DEPTH) levels at most. Adding a new timer sifts it up from
// the tail; a re-arm sifts down, then up when it stayed in its slot; fire
// moves the tail element into the removed slot and sifts it, and pop does
// the same from the top. Tick gives a result and a removal for each expired
// timer, then one closing result. Clear and unknown operations answer the
// cycle after they are taken. After reset the id map is swept to zero, one
// entry a cycle, so busy stays high until the sweep is done.
module indexed_min_heap_timer #(
   parameter int HEAP_DEPTH = 32,
   parameter int ID_COUNT   = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  imht_pkg::req_type req_data,
   output logic              rsp_valid,
   output imht_pkg::rsp_type rsp_data
);

   localparam int HAW  = $clog2(HEAP_DEPTH);
   localparam int CW   = $clog2(HEAP_DEPTH + 1);
   localparam int CMPW = HAW + 1;
   localparam int MAW  = $clog2(ID_COUNT);
   localparam int EW   = $bits(imht_pkg::heap_entry_type);

   // sequencer states
   localparam logic [4:0] S_INIT = 5'd0;
   localparam logic [4:0] S_IDLE = 5'd1;
   localparam logic [4:0] S_LK0  = 5'd2;
   localparam logic [4:0] S_LK1  = 5'd3;
   localparam logic [4:0] S_LK2  = 5'd4;
   localparam logic [4:0] S_RM0  = 5'd5;
   localparam logic [4:0] S_RM1  = 5'd6;
   localparam logic [4:0] S_SD0  = 5'd7;
   localparam logic [4:0] S_SD1  = 5'd8;
   localparam logic [4:0] S_SD2  = 5'd9;
   localparam logic [4:0] S_SD3  = 5'd10;
   localparam logic [4:0] S_SU0  = 5'd11;
   localparam logic [4:0] S_SU1  = 5'd12;
   localparam logic [4:0] S_FIN  = 5'd13;
   localparam logic [4:0] S_POST = 5'd14;
   localparam logic [4:0] S_PP0  = 5'd15;
   localparam logic [4:0] S_PP1  = 5'd16;
   localparam logic [4:0] S_TK0  = 5'd17;
   localparam logic [4:0] S_TK1  = 5'd18;
   localparam logic [4:0] S_TK2  = 5'd19;

   // control state
   logic [4:0]    state_ff, state_in;
   logic [MAW-1:0] sweep_ff, sweep_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers
   imht_pkg::req_type        req_ff, req_in;
   logic [47:0]              exp_ff, exp_in;
   imht_pkg::heap_entry_type cur_ff, cur_in;     // element being sifted (the hole value)
   imht_pkg::heap_entry_type best_ff, best_in;   // chosen child, or heap top on tick
   logic [CMPW-1:0]          bidx_ff, bidx_in;   // slot of best_ff
   logic [HAW-1:0]           i_ff, i_in;         // current hole slot
   logic [HAW-1:0]           start_ff, start_in; // slot where the sift began
   logic [9:0]               top_id_ff, top_id_in;
   imht_pkg::rsp_type        rsp_ff, rsp_in;

   // ram ports
   logic                     heap_we;
   logic [HAW-1:0]           heap_waddr, heap_rd_addr;
   imht_pkg::heap_entry_type heap_wdata, heap_rd;
   logic [EW-1:0]            heap_rd_raw;
   logic                     map_we;
   logic [MAW-1:0]           map_waddr;
   logic [HAW-1:0]           map_wdata, map_rd;

   imht_pkg::alu_req_type alu_req;
   imht_pkg::alu_rsp_type alu_rsp;

   // helpers
   logic [CMPW-1:0] c_idx, c1_idx;
   logic [HAW-1:0]  parent;
   logic            in_range, known;
   logic [30:0]     next_sat;

   imht_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_addr (heap_rd_addr),
      .rd_data (heap_rd_raw)
   );
   assign heap_rd = imht_pkg::heap_entry_type'(heap_rd_raw);

   // id map needs no valid bits: an id is held when its slot is below the
   // count and the heap entry there carries the same id
   imht_ram #(.WIDTH(HAW), .DEPTH(ID_COUNT)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (MAW'(req_ff.id)),
      .rd_data (map_rd)
   );

   imht_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign c_idx    = {i_ff, 1'b1};
   assign c1_idx   = bidx_ff + 1'b1;
   assign parent   = HAW'((i_ff - 1'b1) >> 1);
   assign in_range = 32'(req_ff.id) < ID_COUNT;
   assign known    = in_range && (CMPW'(i_ff) < CMPW'(cnt_ff)) && (heap_rd.id == req_ff.id);
   assign next_sat = (|alu_rsp.value[47:31]) ? imht_pkg::NEXT_MAX : alu_rsp.value[30:0];

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      exp_in       = exp_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      bidx_in      = bidx_ff;
      i_in         = i_ff;
      start_in     = start_ff;
      top_id_in    = top_id_ff;
      rsp_in       = rsp_ff;
      heap_we      = 1'b0;
      heap_waddr   = i_ff;
      heap_wdata   = cur_ff;
      heap_rd_addr = '0;
      map_we       = 1'b0;
      map_waddr    = MAW'(cur_ff.id);
      map_wdata    = i_ff;
      alu_req.sub  = 1'b1;
      alu_req.a    = cur_ff.expiry;
      alu_req.b    = best_ff.expiry;

      case (state_ff)
         S_INIT: begin
            // zero the id map after reset
            map_we    = 1'b1;
            map_waddr = sweep_ff;
            map_wdata = '0;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == MAW'(ID_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // expiry = now + timeout, saturating
            alu_req.sub = 1'b0;
            alu_req.a   = req_data.now_ms;
            alu_req.b   = 48'(req_data.timeout_ms);
            if (start) begin
               req_in = req_data;
               exp_in = alu_rsp.value;
               case (req_data.op)
                  imht_pkg::OP_ADD, imht_pkg::OP_FIRE: begin
                     state_in = S_LK0;
                  end
                  imht_pkg::OP_TICK: begin
                     state_in = S_TK0;
                  end
                  imht_pkg::OP_POP: begin
                     state_in = S_PP0;
                  end
                  imht_pkg::OP_CLEAR: begin
                     cnt_in       = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, 10'd0,
                                       imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, 10'd0,
                                       imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
                  end
               endcase
            end
         end
         S_LK0: begin
            // map read of the request id in flight
            state_in = S_LK1;
         end
         S_LK1: begin
            i_in         = map_rd;
            heap_rd_addr = map_rd;
            state_in     = S_LK2;
         end
         S_LK2: begin
            if (req_ff.op == imht_pkg::OP_ADD) begin
               if (!in_range) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, req_ff.id,
                                    imht_pkg::ST_ABSENT, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end else if (known) begin
                  // re-arm: sift down, then up if it stayed
                  cur_in.expiry = exp_ff;
                  cur_in.id     = req_ff.id;
                  start_in      = i_ff;
                  state_in      = S_SD0;
               end else if (32'(cnt_ff) >= HEAP_DEPTH) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, req_ff.id,
                                    imht_pkg::ST_FULL, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end else begin
                  // new timer at the tail, sift up
                  cur_in.expiry = exp_ff;
                  cur_in.id     = req_ff.id;
                  i_in          = HAW'(cnt_ff);
                  start_in      = HAW'(cnt_ff);
                  cnt_in        = cnt_ff + 1'b1;
                  state_in      = S_SU0;
               end
            end else begin
               if (!known) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_FIRED, req_ff.id,
                                    imht_pkg::ST_ABSENT, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end else begin
                  state_in = S_RM0;
               end
            end
         end
         S_RM0: begin
            // remove slot i: move the tail element into the hole, unless slot i is the tail
            cnt_in = cnt_ff - 1'b1;
            if (CMPW'(i_ff) < CMPW'(cnt_ff - 1'b1)) begin
               heap_rd_addr = HAW'(cnt_ff - 1'b1);
               start_in     = i_ff;
               state_in     = S_RM1;
            end else begin
               state_in = S_POST;
            end
         end
         S_RM1: begin
            cur_in   = heap_rd;
            state_in = S_SD0;
         end
         S_SD0: begin
            if (c_idx < CMPW'(cnt_ff)) begin
               heap_rd_addr = HAW'(c_idx);
               bidx_in      = c_idx;
               state_in     = S_SD1;
            end else begin
               state_in = (i_ff != start_ff) ? S_FIN : S_SU0;
            end
         end
         S_SD1: begin
            best_in = heap_rd;
            if (c1_idx < CMPW'(cnt_ff)) begin
               heap_rd_addr = HAW'(c1_idx);
               state_in     = S_SD2;
            end else begin
               state_in = S_SD3;
            end
         end
         S_SD2: begin
            // right child wins only when strictly earlier
            alu_req.a = heap_rd.expiry;
            alu_req.b = best_ff.expiry;
            if (alu_rsp.lt) begin
               best_in = heap_rd;
               bidx_in = c1_idx;
            end
            state_in = S_SD3;
         end
         S_SD3: begin
            alu_req.a = cur_ff.expiry;
            alu_req.b = best_ff.expiry;
            if (alu_rsp.lt) begin
               state_in = (i_ff != start_ff) ? S_FIN : S_SU0;
            end else begin
               heap_we    = 1'b1;
               heap_waddr = i_ff;
               heap_wdata = best_ff;
               map_we     = 1'b1;
               map_waddr  = MAW'(best_ff.id);
               map_wdata  = i_ff;
               i_in       = HAW'(bidx_ff);
               state_in   = S_SD0;
            end
         end
         S_SU0: begin
            if (i_ff == '0) begin
               state_in = S_FIN;
            end else begin
               heap_rd_addr = parent;
               state_in     = S_SU1;
            end
         end
         S_SU1: begin
            // parent stays only when strictly earlier
            heap_rd_addr = parent;
            alu_req.a    = heap_rd.expiry;
            alu_req.b    = cur_ff.expiry;
            if (alu_rsp.lt) begin
               state_in = S_FIN;
            end else begin
               heap_we    = 1'b1;
               heap_waddr = i_ff;
               heap_wdata = heap_rd;
               map_we     = 1'b1;
               map_waddr  = MAW'(heap_rd.id);
               map_wdata  = i_ff;
               i_in       = parent;
               state_in   = S_SU0;
            end
         end
         S_FIN: begin
            heap_we    = 1'b1;
            heap_waddr = i_ff;
            heap_wdata = cur_ff;
            map_we     = 1'b1;
            map_waddr  = MAW'(cur_ff.id);
            map_wdata  = i_ff;
            state_in   = S_POST;
         end
         S_POST: begin
            case (req_ff.op)
               imht_pkg::OP_ADD: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, req_ff.id,
                                    imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end
               imht_pkg::OP_FIRE: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_FIRED, req_ff.id,
                                    imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end
               imht_pkg::OP_POP: begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, top_id_ff,
                                    imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
                  state_in     = S_IDLE;
               end
               imht_pkg::OP_TICK: begin
                  state_in = S_TK0;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_PP0: begin
            if (cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_ACK, 10'd0,
                                 imht_pkg::ST_ABSENT, 1'b0, 31'd0, 1'b1);
               state_in     = S_IDLE;
            end else begin
               state_in = S_PP1;
            end
         end
         S_PP1: begin
            top_id_in = heap_rd.id;
            i_in      = '0;
            state_in  = S_RM0;
         end
         S_TK0: begin
            if (cnt_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_TICK_DONE, 10'd0,
                                 imht_pkg::ST_OK, 1'b0, 31'd0, 1'b1);
               state_in     = S_IDLE;
            end else begin
               state_in = S_TK1;
            end
         end
         S_TK1: begin
            // expired when now is not below the top expiry
            alu_req.a = req_ff.now_ms;
            alu_req.b = heap_rd.expiry;
            best_in   = heap_rd;
            if (alu_rsp.lt) begin
               state_in = S_TK2;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_EXPIRED, heap_rd.id,
                                 imht_pkg::ST_OK, 1'b0, 31'd0, 1'b0);
               i_in         = '0;
               state_in     = S_RM0;
            end
         end
         S_TK2: begin
            // time left to the earliest expiry
            alu_req.a    = best_ff.expiry;
            alu_req.b    = req_ff.now_ms;
            rsp_valid_in = 1'b1;
            rsp_in       = imht_pkg::make_rsp(imht_pkg::KIND_TICK_DONE, 10'd0,
                              imht_pkg::ST_OK, 1'b1, next_sat, 1'b1);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         sweep_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      exp_ff    <= exp_in;
      cur_ff    <= cur_in;
      best_ff   <= best_in;
      bidx_ff   <= bidx_in;
      i_ff      <= i_in;
      start_ff  <= start_in;
      top_id_ff <= top_id_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // heap never holds more than its depth
   `ASSERT_IMPLIES(a_cnt_bound, clock, reset, 1'b1, 32'(cnt_ff) <= HEAP_DEPTH)
   // an accepted request either keeps the block busy or answers at once
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy || rsp_valid)
   // the final result of a request coincides with the return to idle
   `ASSERT_IMPLIES(a_last_idle, clock, reset, rsp_valid && rsp_data.last, !busy)
   // an intermediate tick result always has more work behind it
   `ASSERT_IMPLIES(a_more_busy, clock, reset, rsp_valid && !rsp_data.last, busy)

endmodule
